/* rtl/smtp_pkg.sv */
package smtp_pkg;

  typedef enum logic [2:0] {
    REPLY_NONE = 3'd0,
    REPLY_OK   = 3'd1,
    REPLY_BYE  = 3'd2,
    REPLY_502  = 3'd3,
    REPLY_503  = 3'd4,
    REPLY_500  = 3'd5,
    REPLY_354  = 3'd6
  } reply_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SENDER  = 3'd1,
    ACT_RCPT    = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_TEXT    = 3'd4,
    ACT_DELIVER = 3'd5
  } action_e;

  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_DOT  = 8'd46;
  localparam logic [7:0] CHAR_LT   = 8'd60;
  localparam logic [7:0] CHAR_GT   = 8'd62;
  localparam logic [7:0] CHAR_AT   = 8'd64;
  localparam logic [7:0] CHAR_LC_A = 8'd97;
  localparam logic [7:0] CHAR_LC_Z = 8'd122;
  localparam logic [7:0] CASE_BIT  = 8'd32;

  localparam logic [31:0] VERB_NOOP = "NOOP";
  localparam logic [31:0] VERB_HELP = "HELP";
  localparam logic [31:0] VERB_VRFY = "VRFY";
  localparam logic [31:0] VERB_EXPN = "EXPN";
  localparam logic [31:0] VERB_HELO = "HELO";
  localparam logic [31:0] VERB_EHLO = "EHLO";
  localparam logic [31:0] VERB_QUIT = "QUIT";
  localparam logic [31:0] VERB_RSET = "RSET";
  localparam logic [31:0] VERB_MAIL = "MAIL";
  localparam logic [31:0] VERB_RCPT = "RCPT";
  localparam logic [31:0] VERB_DATA = "DATA";

endpackage

/* rtl/smtp_command_sequencer_core.sv */
// SMTP command sequencer. The client byte stream enters one beat per cycle on
// the input channel; carriage returns are dropped and a line feed closes the
// line. Every line feed produces exactly one result beat in the next cycle, with
// the reply code, envelope action, address offset and length, the line length
// and the session state after the line; other bytes produce none. The block
// takes one byte every cycle and only stalls its input while a finished result
// is held by a stalled output. Bytes beyond MAX_LINE in a line are ignored and
// such a line always counts as holding a malformed address.
module smtp_command_sequencer_core #(
  parameter int MAX_LINE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output smtp_pkg::reply_e      reply_o,
  output smtp_pkg::action_e     action_o,
  output logic [9:0]            addr_start_o,
  output logic [9:0]            addr_length_o,
  output logic [10:0]           line_length_o,
  output logic [2:0]            session_state_o
);
  import smtp_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int PW = $clog2(MAX_LINE);
  localparam logic [LW-1:0] LINE_MAX = LW'(MAX_LINE);

  typedef enum logic [2:0] {
    PH_GREET = 3'd0,
    PH_MAIL  = 3'd1,
    PH_RCPT1 = 3'd2,
    PH_RCPT2 = 3'd3,
    PH_DATA  = 3'd4,
    PH_QUIT  = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LW-1:0]   line_pos_q, line_pos_d;
  logic [3:0][7:0] verb_q, verb_d;
  logic [PW-1:0]   open_pos_q, open_pos_d;
  logic            open_found_q, open_found_d;
  logic [PW-1:0]   close_pos_q, close_pos_d;
  logic            close_found_q, close_found_d;
  logic            at_open_q, at_open_d;
  logic            at_close_q, at_close_d;

  logic            out_valid_q, out_valid_d;
  reply_e          reply_q, reply_d;
  action_e         action_q, action_d;
  logic [9:0]      addr_start_q, addr_start_d;
  logic [9:0]      addr_length_q, addr_length_d;
  logic [10:0]     line_length_q;
  phase_e          state_out_q;

  logic            in_acc;
  logic            is_lf;
  logic            take;
  logic [7:0]      folded;
  logic [31:0]     verb;
  logic            addr_ok;
  logic [PW-1:0]   addr_len;
  logic [PW:0]     addr_first;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_lf      = (rx_byte_i == CHAR_LF);
  assign take       = in_acc && !is_lf && (rx_byte_i != CHAR_CR) &&
                      (phase_q != PH_DONE) && (line_pos_q < LINE_MAX);
  assign folded     = (rx_byte_i >= CHAR_LC_A && rx_byte_i <= CHAR_LC_Z) ?
                      rx_byte_i - CASE_BIT : rx_byte_i;
  assign verb       = (line_pos_q >= LW'(4)) ? verb_q : 32'd0;
  assign addr_len   = close_pos_q - open_pos_q - PW'(1);
  assign addr_first = {1'b0, open_pos_q} + (PW+1)'(1);
  assign addr_ok    = open_found_q && close_found_q && (close_pos_q > open_pos_q) &&
                      (line_pos_q < LINE_MAX) && (addr_len >= PW'(3)) && at_close_q;

  always_comb begin
    line_pos_d    = line_pos_q;
    verb_d        = verb_q;
    open_pos_d    = open_pos_q;
    open_found_d  = open_found_q;
    close_pos_d   = close_pos_q;
    close_found_d = close_found_q;
    at_open_d     = at_open_q;
    at_close_d    = at_close_q;
    if (take) begin
      if (line_pos_q < LW'(4)) begin
        verb_d[~line_pos_q[1:0]] = folded;
      end
      if (rx_byte_i == CHAR_LT && !open_found_q) begin
        open_found_d = 1'b1;
        open_pos_d   = PW'(line_pos_q);
      end else if (rx_byte_i == CHAR_GT) begin
        close_found_d = 1'b1;
        close_pos_d   = PW'(line_pos_q);
        at_close_d    = open_found_q && at_open_q;
      end else if (rx_byte_i == CHAR_AT && open_found_q) begin
        at_open_d = 1'b1;
      end
      line_pos_d = line_pos_q + LW'(1);
    end else if (in_acc && is_lf) begin
      line_pos_d    = '0;
      verb_d        = '0;
      open_pos_d    = '0;
      open_found_d  = 1'b0;
      close_pos_d   = '0;
      close_found_d = 1'b0;
      at_open_d     = 1'b0;
      at_close_d    = 1'b0;
    end
  end

  always_comb begin
    reply_d  = REPLY_NONE;
    action_d = ACT_NONE;
    phase_d  = phase_q;
    unique case (phase_q)
      PH_DATA: begin
        if (line_pos_q == LW'(1) && verb_q[3] == CHAR_DOT) begin
          reply_d  = REPLY_OK;
          action_d = ACT_DELIVER;
          phase_d  = PH_QUIT;
        end else begin
          action_d = ACT_TEXT;
        end
      end
      PH_GREET, PH_MAIL, PH_RCPT1, PH_RCPT2, PH_QUIT: begin
        if (verb == VERB_NOOP || verb == VERB_HELP) begin
          reply_d = REPLY_OK;
        end else if (verb == VERB_VRFY || verb == VERB_EXPN) begin
          reply_d = REPLY_502;
        end else if (verb == VERB_QUIT) begin
          reply_d = REPLY_BYE;
          phase_d = PH_DONE;
        end else if (verb == VERB_RSET) begin
          reply_d = REPLY_OK;
          if (phase_q != PH_GREET) begin
            action_d = ACT_CLEAR;
            phase_d  = PH_MAIL;
          end
        end else if (phase_q == PH_GREET) begin
          if (verb == VERB_HELO || verb == VERB_EHLO) begin
            reply_d = REPLY_OK;
            phase_d = PH_MAIL;
          end else if (verb == VERB_MAIL || verb == VERB_RCPT || verb == VERB_DATA) begin
            reply_d = REPLY_503;
          end else begin
            reply_d = REPLY_500;
          end
        end else if (verb == VERB_MAIL && phase_q == PH_MAIL) begin
          if (addr_ok) begin
            reply_d  = REPLY_OK;
            action_d = ACT_SENDER;
            phase_d  = PH_RCPT1;
          end else begin
            reply_d = REPLY_500;
          end
        end else if (verb == VERB_RCPT && (phase_q == PH_RCPT1 || phase_q == PH_RCPT2)) begin
          if (addr_ok) begin
            reply_d  = REPLY_OK;
            action_d = ACT_RCPT;
            phase_d  = PH_RCPT2;
          end else begin
            reply_d = REPLY_500;
          end
        end else if (verb == VERB_DATA && phase_q == PH_RCPT2) begin
          reply_d = REPLY_354;
          phase_d = PH_DATA;
        end else if (verb == VERB_MAIL || verb == VERB_RCPT || verb == VERB_DATA) begin
          reply_d = REPLY_503;
        end else begin
          reply_d = REPLY_500;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
    if (action_d == ACT_SENDER || action_d == ACT_RCPT) begin
      addr_start_d  = 10'(addr_first);
      addr_length_d = 10'(addr_len);
    end else begin
      addr_start_d  = '0;
      addr_length_d = '0;
    end
  end

  assign out_valid_d = (in_acc && is_lf) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_GREET;
      line_pos_q    <= '0;
      verb_q        <= '0;
      open_pos_q    <= '0;
      open_found_q  <= 1'b0;
      close_pos_q   <= '0;
      close_found_q <= 1'b0;
      at_open_q     <= 1'b0;
      at_close_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      reply_q       <= REPLY_NONE;
      action_q      <= ACT_NONE;
      addr_start_q  <= '0;
      addr_length_q <= '0;
      line_length_q <= '0;
      state_out_q   <= PH_GREET;
    end else begin
      line_pos_q    <= line_pos_d;
      verb_q        <= verb_d;
      open_pos_q    <= open_pos_d;
      open_found_q  <= open_found_d;
      close_pos_q   <= close_pos_d;
      close_found_q <= close_found_d;
      at_open_q     <= at_open_d;
      at_close_q    <= at_close_d;
      out_valid_q   <= out_valid_d;
      if (in_acc && is_lf) begin
        phase_q       <= phase_d;
        reply_q       <= reply_d;
        action_q      <= action_d;
        addr_start_q  <= addr_start_d;
        addr_length_q <= addr_length_d;
        line_length_q <= 11'(line_pos_q);
        state_out_q   <= phase_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reply_o         = reply_q;
  assign action_o        = action_q;
  assign addr_start_o    = addr_start_q;
  assign addr_length_o   = addr_length_q;
  assign line_length_o   = line_length_q;
  assign session_state_o = state_out_q;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_envelope_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_SENDER || action_o == ACT_RCPT) |-> reply_o == REPLY_OK)
    else $error("envelope update without 250 reply");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_SENDER && action_o != ACT_RCPT
    |-> addr_start_o == 10'd0 && addr_length_o == 10'd0)
    else $error("address fields set without envelope update");

  a_bye_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_o == REPLY_BYE |-> session_state_o == PH_DONE)
    else $error("closing reply without done state");
`endif

endmodule
